// ===== src/eet_pkg.sv =====
// Shared types, field widths and codes for the expiring entry table.
// Used by every module of the block except eet_ram; no dependencies.
package eet_pkg;

  localparam int KEY_W  = 32;
  localparam int TAG_W  = 32;
  localparam int TIME_W = 48;
  localparam int CAP_W  = 5;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;
  localparam int WORD_W = KEY_W + TAG_W + TIME_W;

  localparam int MaxEntriesDef = 16;
  localparam logic [CAP_W-1:0] CapResetVal = 5'd16;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD_OK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LIVE    = 2'd3;

  // compare unit results
  typedef struct packed {
    logic key_hit;
    logic expired;
  } cmp_t;

endpackage

// ===== src/eet_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module eet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/eet_cmp.sv =====
// Shared compare unit: key match and expiry test against one stored entry.
// Depends on eet_pkg.
module eet_cmp (
  input  logic [eet_pkg::KEY_W-1:0]  req_key_i,
  input  logic [eet_pkg::KEY_W-1:0]  ent_key_i,
  input  logic [eet_pkg::TIME_W-1:0] now_i,
  input  logic [eet_pkg::TIME_W-1:0] ent_exp_i,
  output eet_pkg::cmp_t              cmp_o
);
  import eet_pkg::*;

  always_comb begin
    cmp_o.key_hit = (req_key_i == ent_key_i);
    cmp_o.expired = (now_i > ent_exp_i);
  end

endmodule

// ===== src/expiring_entry_table.sv =====
// Expiring entry table: add/update, swap-remove and expiry sweep over a small RAM.
// Requests: add/remove search the n present entries in order (one RAM read + compare
// per entry), a swap move follows a removal; tick walks the entries from the top down.
// Throughput: one request at a time; start_i is taken only while busy_o is low.
// Results leave through a register, in the cycle after they are decided; no stall.
// Reset clears the entry count and sets capacity to 16; RAM contents are not reset.
module expiring_entry_table #(
  parameter int MaxEntries = eet_pkg::MaxEntriesDef,
  localparam int IW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
  localparam int CW = $clog2(MaxEntries + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [eet_pkg::OP_W-1:0]     opcode_i,
  input  logic [eet_pkg::KEY_W-1:0]    key_i,
  input  logic [eet_pkg::TAG_W-1:0]    target_tag_i,
  input  logic [eet_pkg::TIME_W-1:0]   expiry_time_i,
  input  logic [eet_pkg::TIME_W-1:0]   now_time_i,
  input  logic                         cfg_we_i,
  input  logic [eet_pkg::CAP_W-1:0]    cfg_wdata_i,
  output logic                         res_valid_o,
  output logic [eet_pkg::KIND_W-1:0]   kind_o,
  output logic [eet_pkg::KEY_W-1:0]    entry_key_o,
  output logic [eet_pkg::TAG_W-1:0]    entry_tag_o,
  output logic                         last_o
);
  import eet_pkg::*;

  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_TRD  = 3'd3;
  localparam logic [2:0] S_TCMP = 3'd4;
  localparam logic [2:0] S_MOVE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic [IW-1:0]     dst_q, dst_d;
  logic [CAP_W-1:0]  cap_q;
  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [TIME_W-1:0] exp_q, exp_d;
  logic [TIME_W-1:0] now_q, now_d;

  logic              res_valid_q, res_valid_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [KEY_W-1:0]  rkey_q, rkey_d;
  logic [TAG_W-1:0]  rtag_q, rtag_d;
  logic              last_q, last_d;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [TAG_W-1:0]  rd_tag;
  logic [TIME_W-1:0] rd_exp;
  cmp_t              cmp;

  logic [CW-1:0]     cnt_m1;
  logic              tbl_full;

  assign rd_key = rdata[WORD_W-1 -: KEY_W];
  assign rd_tag = rdata[TIME_W +: TAG_W];
  assign rd_exp = rdata[TIME_W-1:0];

  assign cnt_m1   = cnt_q - 1'b1;
  // capacity above MaxEntries acts as MaxEntries
  assign tbl_full = (CMPW'(cnt_q) >= CMPW'(cap_q)) || (CMPW'(cnt_q) >= CMPW'(MaxEntries));

  eet_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MaxEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  eet_cmp u_cmp (
    .req_key_i (key_q),
    .ent_key_i (rd_key),
    .now_i     (now_q),
    .ent_exp_i (rd_exp),
    .cmp_o     (cmp)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    dst_d       = dst_q;
    op_d        = op_q;
    key_d       = key_q;
    tag_d       = tag_q;
    exp_d       = exp_q;
    now_d       = now_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    rkey_d      = rkey_q;
    rtag_d      = rtag_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = dst_q;
    wdata       = {key_q, tag_q, exp_q};
    raddr       = scan_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = opcode_i;
          key_d = key_i;
          tag_d = target_tag_i;
          exp_d = expiry_time_i;
          now_d = now_time_i;
          if (opcode_i == OP_ADD || opcode_i == OP_REMOVE) begin
            scan_d  = '0;
            state_d = S_SRCH;
          end else if (opcode_i == OP_TICK && cnt_q != '0) begin
            scan_d  = cnt_q;
            state_d = S_TRD;
          end
        end
      end

      S_SRCH: begin
        if (scan_q == cnt_q) begin
          // key absent
          state_d = S_IDLE;
          if (op_q == OP_ADD) begin
            res_valid_d = 1'b1;
            rkey_d      = key_q;
            last_d      = 1'b1;
            if (tbl_full) begin
              kind_d = KIND_FULL;
              rtag_d = '0;
            end else begin
              kind_d = KIND_ADD_OK;
              rtag_d = tag_q;
              we     = 1'b1;
              waddr  = cnt_q[IW-1:0];
              cnt_d  = cnt_q + 1'b1;
            end
          end
        end else begin
          state_d = S_SCMP;
        end
      end

      S_SCMP: begin
        if (cmp.key_hit) begin
          if (op_q == OP_ADD) begin
            we          = 1'b1;
            waddr       = scan_q[IW-1:0];
            res_valid_d = 1'b1;
            kind_d      = KIND_ADD_OK;
            rkey_d      = key_q;
            rtag_d      = tag_q;
            last_d      = 1'b1;
            state_d     = S_IDLE;
          end else if (scan_q < cnt_m1) begin
            raddr   = cnt_m1[IW-1:0];
            dst_d   = scan_q[IW-1:0];
            state_d = S_MOVE;
          end else begin
            cnt_d   = cnt_m1;
            state_d = S_IDLE;
          end
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_SRCH;
        end
      end

      S_TRD: begin
        scan_d  = scan_q - 1'b1;
        raddr   = scan_d[IW-1:0];
        state_d = S_TCMP;
      end

      S_TCMP: begin
        res_valid_d = 1'b1;
        kind_d      = cmp.expired ? KIND_EXPIRED : KIND_LIVE;
        rkey_d      = rd_key;
        rtag_d      = rd_tag;
        last_d      = (scan_q == '0);
        if (cmp.expired && scan_q < cnt_m1) begin
          raddr   = cnt_m1[IW-1:0];
          dst_d   = scan_q[IW-1:0];
          state_d = S_MOVE;
        end else begin
          if (cmp.expired) begin
            cnt_d = cnt_m1;
          end
          state_d = (scan_q == '0) ? S_IDLE : S_TRD;
        end
      end

      S_MOVE: begin
        // last entry fills the vacated slot
        we    = 1'b1;
        waddr = dst_q;
        wdata = rdata;
        cnt_d = cnt_m1;
        if (op_q == OP_TICK && scan_q != '0) begin
          state_d = S_TRD;
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_q       <= CapResetVal;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    dst_q  <= dst_d;
    op_q   <= op_d;
    key_q  <= key_d;
    tag_q  <= tag_d;
    exp_q  <= exp_d;
    now_q  <= now_d;
    kind_q <= kind_d;
    rkey_q <= rkey_d;
    rtag_q <= rtag_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign kind_o      = kind_q;
  assign entry_key_o = rkey_q;
  assign entry_tag_o = rtag_q;
  assign last_o      = last_q;

endmodule

// ===== src/eet_chk.sv =====
// Port-level checker for the expiring entry table, bound to the top level.
// Depends on eet_pkg and expiring_entry_table.
module eet_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_i,
  input logic                       res_valid_i,
  input logic [eet_pkg::KIND_W-1:0] kind_i,
  input logic                       last_i
);
  import eet_pkg::*;

  // a result is always decided while a request is in flight
  a_res_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> $past(busy_i))
    else $error("result without a request in flight");

  // no result in the cycle right after a request is taken
  a_no_early_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> !res_valid_i)
    else $error("result too early after request");

  // add results are single and final
  a_add_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (kind_i == KIND_ADD_OK || kind_i == KIND_FULL)) |-> last_i)
    else $error("add result not marked last");

  // final result closes the request: it is never directly followed by another result
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && last_i) |=> !res_valid_i)
    else $error("activity after final result");

  // sweep still running after a non-final result
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !last_i) |=> busy_i)
    else $error("sweep ended without a final result");

endmodule

bind expiring_entry_table eet_chk u_eet_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_i      (busy_o),
  .res_valid_i (res_valid_o),
  .kind_i      (kind_o),
  .last_i      (last_o)
);

// ===== tb/eet_checker.sv =====
// Checker for the expiring entry table: watches the request, config and result ports,
// keeps its own copy of the table and compares every result. Depends on eet_pkg.
module eet_checker
  import eet_pkg::*;
#(
  parameter int MaxEntries = MaxEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [TAG_W-1:0]  target_tag_i,
  input  logic [TIME_W-1:0] expiry_time_i,
  input  logic [TIME_W-1:0] now_time_i,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              res_valid_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [KEY_W-1:0]  entry_key_i,
  input  logic [TAG_W-1:0]  entry_tag_i,
  input  logic              last_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } table_result_t;

  table_result_t     due_results[$];
  logic [CAP_W-1:0]  capacity;
  int                entry_count;
  logic [KEY_W-1:0]  slot_key[MaxEntries];
  logic [TAG_W-1:0]  slot_tag[MaxEntries];
  logic [TIME_W-1:0] slot_expiry[MaxEntries];
  int unsigned       mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic int find_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < entry_count; i++) begin
      if (slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // swap-remove: the tail entry moves into the freed slot
  function automatic void drop_slot(input int idx);
    int tail;
    tail = entry_count - 1;
    if (idx < tail) begin
      slot_key[idx] = slot_key[tail];
      slot_tag[idx] = slot_tag[tail];
      slot_expiry[idx] = slot_expiry[tail];
    end
    entry_count--;
  endfunction

  function automatic void push_outcome(input logic [KIND_W-1:0] kind,
                                       input logic [KEY_W-1:0] k,
                                       input logic [TAG_W-1:0] t, input logic last);
    table_result_t r;
    r.kind = kind;
    r.key = k;
    r.tag = t;
    r.last = last;
    due_results.push_back(r);
  endfunction

  function automatic void predict_table_op(input logic [OP_W-1:0] op,
                                           input logic [KEY_W-1:0] k,
                                           input logic [TAG_W-1:0] t,
                                           input logic [TIME_W-1:0] expiry,
                                           input logic [TIME_W-1:0] now_t);
    int slot;
    int room;
    room = (capacity > MaxEntries) ? MaxEntries : int'(capacity);
    case (op)
      OP_ADD: begin
        slot = find_key(k);
        if (slot < 0 && entry_count >= room) begin
          push_outcome(KIND_FULL, k, '0, 1'b1);
        end else begin
          if (slot < 0) begin
            slot = entry_count;
            slot_key[slot] = k;
            entry_count++;
          end
          slot_tag[slot] = t;
          slot_expiry[slot] = expiry;
          push_outcome(KIND_ADD_OK, k, t, 1'b1);
        end
      end
      OP_REMOVE: begin
        slot = find_key(k);
        if (slot >= 0) drop_slot(slot);
      end
      OP_TICK: begin
        // walk ends at slot 0, so that result is always the last one
        for (int i = entry_count - 1; i >= 0; i--) begin
          if (now_t > slot_expiry[i]) begin
            push_outcome(KIND_EXPIRED, slot_key[i], slot_tag[i], i == 0);
            drop_slot(i);
          end else begin
            push_outcome(KIND_LIVE, slot_key[i], slot_tag[i], i == 0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      capacity = CapResetVal;
      entry_count = 0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d key %h tag %h last %0b",
                 kind_i, entry_key_i, entry_tag_i, last_i);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind_i);
            mismatches++;
          end
          if (entry_key_i !== want.key) begin
            $error("entry_key mismatch: expected %h, actual %h", want.key, entry_key_i);
            mismatches++;
          end
          if (entry_tag_i !== want.tag) begin
            $error("entry_tag mismatch: expected %h, actual %h", want.tag, entry_tag_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, last_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (start_i && !busy_i) begin
        predict_table_op(opcode_i, key_i, target_tag_i, expiry_time_i, now_time_i);
      end
      pending_o <= due_results.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// ===== tb/expiring_entry_table_tb.sv =====
// Testbench top for expiring_entry_table: clock, reset, request and capacity stimulus,
// and the verdict. Depends on eet_pkg, expiring_entry_table and eet_checker.
module expiring_entry_table_tb;
  import eet_pkg::*;

  localparam logic [OP_W-1:0] OpUnused = 2'd3;
  localparam int KeyPoolSize = 20;
  localparam int DrainCycles = 64;
  localparam int PhaseCount = 8;
  localparam int RandomPerPhase = 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   opcode = OP_ADD;
  logic [KEY_W-1:0]  key = '0;
  logic [TAG_W-1:0]  target_tag = '0;
  logic [TIME_W-1:0] expiry_time = '0;
  logic [TIME_W-1:0] now_time = '0;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              res_valid;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  entry_key;
  logic [TAG_W-1:0]  entry_tag;
  logic              res_last;
  int unsigned       fail_count;
  int unsigned       pending;

  logic              burst = 1'b0;  // no sender gaps while set
  logic [KEY_W-1:0]  key_pool[KeyPoolSize];
  logic [TIME_W-1:0] time_base = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  expiring_entry_table i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .opcode_i      (opcode),
    .key_i         (key),
    .target_tag_i  (target_tag),
    .expiry_time_i (expiry_time),
    .now_time_i    (now_time),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .res_valid_o   (res_valid),
    .kind_o        (kind),
    .entry_key_o   (entry_key),
    .entry_tag_o   (entry_tag),
    .last_o        (res_last)
  );

  eet_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .opcode_i      (opcode),
    .key_i         (key),
    .target_tag_i  (target_tag),
    .expiry_time_i (expiry_time),
    .now_time_i    (now_time),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .res_valid_i   (res_valid),
    .kind_i        (kind),
    .entry_key_i   (entry_key),
    .entry_tag_i   (entry_tag),
    .last_i        (res_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // start stays high across back-to-back requests
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [TAG_W-1:0] t, input logic [TIME_W-1:0] expiry,
                              input logic [TIME_W-1:0] now_t);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode <= op;
    key <= k;
    target_tag <= t;
    expiry_time <= expiry;
    now_time <= now_t;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // removes leave no result behind, so also wait out busy and the tail latency
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int pick;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, KeyPoolSize - 1)];
    if (pick < 4) begin
      send_request(OpUnused, $urandom, $urandom, rand_time(), rand_time());
    end else if (pick < 10) begin
      send_request(OP_ADD, $urandom, $urandom, rand_time(), rand_time());
    end else if (pick < 55) begin
      send_request(OP_ADD, k, $urandom, time_base + TIME_W'($urandom_range(0, 200)),
                   rand_time());
    end else if (pick < 75) begin
      send_request(OP_REMOVE, k, $urandom, rand_time(), rand_time());
    end else begin
      send_request(OP_TICK, $urandom, $urandom, rand_time(),
                   time_base + TIME_W'($urandom_range(0, 260)));
      time_base = time_base + TIME_W'($urandom_range(0, 40));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty sweep, extremes, update, absent remove, unused opcode
    send_request(OP_TICK, '0, '0, '0, '1);
    send_request(OP_ADD, '0, '0, '0, '0);
    send_request(OP_ADD, '1, '1, '1, '0);
    send_request(OP_ADD, '0, 32'hA5A5_A5A5, '0, '1);
    send_request(OP_REMOVE, 32'h1234_5678, '1, '1, '1);
    send_request(OpUnused, '1, '1, '1, '1);
    send_request(OP_TICK, '1, '1, '1, '0);
    send_request(OP_TICK, '0, '0, '0, 48'd1);
    // table full at capacity one, update still allowed
    drain();
    write_capacity(5'd1);
    send_request(OP_ADD, 32'd3, 32'h5A5A_5A5A, 48'd10, '0);
    send_request(OP_ADD, '1, 32'h0F0F_0F0F, '1, '0);
    // capacity zero, below the entry count
    drain();
    write_capacity(5'd0);
    send_request(OP_ADD, '1, 32'hF0F0_F0F0, '1, '0);
    send_request(OP_ADD, 32'd5, 32'd6, 48'd7, '0);
    // capacity above the table size
    drain();
    write_capacity(5'd31);
    send_request(OP_ADD, 32'd7, 32'd70, 48'd100, '0);
    send_request(OP_ADD, 32'd8, 32'd80, 48'd200, '0);
    send_request(OP_TICK, '0, '0, '0, 48'd150);
    send_request(OP_TICK, '0, '0, '0, '1);
    send_request(OP_REMOVE, '1, '0, '0, '0);
    send_request(OP_TICK, '0, '0, '0, '1);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: cap = 5'd16;
        1: cap = 5'd1;
        2: cap = 5'd0;
        3: cap = 5'd31;
        4: cap = 5'd5;
        5: cap = 5'd17;
        default: cap = CAP_W'($urandom_range(2, 15));
      endcase
      drain();
      write_capacity(cap);
      burst = (phase % 3 == 1);
      time_base = rand_time();
      for (int i = 0; i < KeyPoolSize; i++) key_pool[i] = $urandom;
      if (cap >= 5'd16) begin
        // fill past the top, then sweep a full table
        for (int i = 0; i < KeyPoolSize; i++) begin
          send_request(OP_ADD, key_pool[i], $urandom,
                       time_base + TIME_W'($urandom_range(150, 200)), rand_time());
        end
        send_request(OP_TICK, $urandom, $urandom, rand_time(), time_base);
      end
      for (int i = 0; i < RandomPerPhase; i++) random_request();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("expiring_entry_table verification clean");
    end else begin
      $display("expiring_entry_table verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("expiring_entry_table verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/eet_pkg.sv
src/eet_ram.sv
src/eet_cmp.sv
src/expiring_entry_table.sv
src/eet_chk.sv
tb/eet_checker.sv
tb/expiring_entry_table_tb.sv
